// ----- hw/rtl/bpred_pkg.sv -----
// Shared types and constants for the bimodal / BTB / return-stack branch predictor.
package bpred_pkg;

	typedef enum logic [0:0] {
		KIND_PREDICT = 1'b0,
		KIND_TRAIN   = 1'b1
	} kind_t;

	localparam int unsigned PC_W     = 64;
	localparam int unsigned LEN_W    = 3;
	localparam int unsigned OFF_W    = 21;
	localparam int unsigned IMM_W    = 12;
	localparam int unsigned TAG_LSB  = 7;
	localparam int unsigned TAG_W    = 16;

	// Direction entry: {set, counter[1:0]}
	localparam int unsigned DIR_ENT_W = 3;
	localparam logic [1:0] CTR_TAKEN_LIMIT = 2'd2;
	localparam logic [1:0] CTR_MAX         = 2'd3;
	localparam logic [1:0] CTR_MIN         = 2'd0;
	localparam logic [1:0] CTR_INIT_TAKEN  = 2'd2;
	localparam logic [1:0] CTR_INIT_NOT    = 2'd1;

	// Return stack update for one transaction leaving the work stage.
	typedef struct packed {
		logic pop;
		logic push;
		logic flush;
	} ras_op_t;

endpackage

// ----- hw/rtl/bpred_ras.sv -----
// Return address stack: circular memory with base pointer, drops oldest on overflow.
module bpred_ras #(
	parameter int unsigned RETURN_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpred_pkg::ras_op_t             op,
	input  logic [bpred_pkg::PC_W-1:0]     push_data,
	output logic                           nonempty,
	output logic [bpred_pkg::PC_W-1:0]     top
);
	import bpred_pkg::*;

	localparam int unsigned PW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
	localparam int unsigned CW = $clog2(RETURN_DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(RETURN_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(RETURN_DEPTH);

	logic [PC_W-1:0] mem [0:RETURN_DEPTH-1];

	logic [PW-1:0] base_q, base_n;
	logic [CW-1:0] count_q, count_n, count_pop, count_m1;
	logic [SW-1:0] wsum, tsum;
	logic [PW-1:0] waddr, taddr;
	logic [PC_W-1:0] top_q;

	always_comb begin
		count_pop = (op.pop && count_q != '0) ? count_q - CW'(1) : count_q;
		wsum = SW'(base_q) + SW'(count_pop);
		if (wsum >= DEPTH_S) begin
			wsum = wsum - DEPTH_S;
		end
		base_n  = base_q;
		count_n = count_pop;
		waddr   = wsum[PW-1:0];
		if (op.push) begin
			if (count_pop == DEPTH_C) begin
				// full: overwrite the oldest slot and advance the base
				waddr   = base_q;
				base_n  = (SW'(base_q) + SW'(1) >= DEPTH_S) ? '0 : base_q + PW'(1);
				count_n = DEPTH_C;
			end else begin
				count_n = count_pop + CW'(1);
			end
		end
		if (op.flush) begin
			count_n = '0;
		end
		count_m1 = (count_n == '0) ? '0 : count_n - CW'(1);
		tsum = SW'(base_n) + SW'(count_m1);
		if (tsum >= DEPTH_S) begin
			tsum = tsum - DEPTH_S;
		end
		taddr = tsum[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= '0;
		end else begin
			base_q  <= base_n;
			count_q <= count_n;
		end
	end

	// top_q always tracks the entry at the top of the current stack
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[waddr] <= push_data;
			top_q      <= push_data;
		end else begin
			top_q      <= mem[taddr];
		end
	end

	assign nonempty = (count_q != '0);
	assign top      = top_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("return stack count out of range");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(base_q) < DEPTH_S)
		else $error("return stack base out of range");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		op.flush |=> count_q == '0)
		else $error("return stack not empty after flush");

endmodule

// ----- hw/rtl/branch_predictor_bimodal_btb_ras.sv -----
// Top level of the branch predictor: bimodal direction table, tagged BTB, return stack.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-----------------------------------------------
//  request | req_valid  | req_stall  | kind, pc, inst_length, class bits, branch_offset,
//          |            |            | jump_immediate, actual_next_pc, mispredicted
//  result  | pred_valid | pred_stall | predicted_pc (predict transactions only)
//
// One transaction per cycle sustained while no clear sweep runs and no predict waits on
// a stalled result: a request is registered into the work stage together with the table
// reads, and the prediction then moves from the work stage into the output register.
// Train transactions give no result. Table state is updated as a transaction leaves the
// work stage; the next transaction's table reads forward that write, so back-to-back
// requests see up-to-date state. After reset the direction and tag tables are swept
// clear, one entry per cycle, over max(DIRECTION_ENTRIES, TARGET_ENTRIES) entries (256 by
// default); req_stall is high during the sweep. A stalled result holds the work stage
// only for a following predict; train transactions keep flowing past a full output register.
module branch_predictor_bimodal_btb_ras #(
	parameter int unsigned DIRECTION_ENTRIES = 256,
	parameter int unsigned TARGET_ENTRIES    = 64,
	parameter int unsigned RETURN_DEPTH      = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 kind,
	input  logic [bpred_pkg::PC_W-1:0]           pc,
	input  logic [bpred_pkg::LEN_W-1:0]          inst_length,
	input  logic                                 is_conditional,
	input  logic                                 is_indirect,
	input  logic                                 is_return,
	input  logic                                 is_call,
	input  logic signed [bpred_pkg::OFF_W-1:0]   branch_offset,
	input  logic signed [bpred_pkg::IMM_W-1:0]   jump_immediate,
	input  logic [bpred_pkg::PC_W-1:0]           actual_next_pc,
	input  logic                                 mispredicted,
	// result channel
	output logic                                 pred_valid,
	input  logic                                 pred_stall,
	output logic [bpred_pkg::PC_W-1:0]           predicted_pc
);
	import bpred_pkg::*;

	localparam int unsigned DW    = $clog2(DIRECTION_ENTRIES);
	localparam int unsigned TW    = $clog2(TARGET_ENTRIES);
	localparam int unsigned CLR_N = (DIRECTION_ENTRIES > TARGET_ENTRIES) ?
	                                DIRECTION_ENTRIES : TARGET_ENTRIES;
	localparam int unsigned CLRW  = $clog2(CLR_N);
	localparam logic [DW-1:0]   DIR_MASK  = DW'(DIRECTION_ENTRIES - 1);
	localparam logic [TW-1:0]   TGT_MASK  = TW'(TARGET_ENTRIES - 1);
	localparam logic [CLRW:0]   DIR_N_C   = (CLRW + 1)'(DIRECTION_ENTRIES);
	localparam logic [CLRW:0]   TGT_N_C   = (CLRW + 1)'(TARGET_ENTRIES);
	localparam logic [CLRW-1:0] CLR_LAST  = CLRW'(CLR_N - 1);
	localparam int unsigned     TENT_W    = TAG_W + 1;

	// ---------------- tables ----------------
	logic [DIR_ENT_W-1:0] dir_mem  [0:DIRECTION_ENTRIES-1];
	logic [TENT_W-1:0]    tag_mem  [0:TARGET_ENTRIES-1];
	logic [PC_W-1:0]      addr_mem [0:TARGET_ENTRIES-1];

	// ---------------- clear sweep ----------------
	logic            clearing_q;
	logic [CLRW-1:0] clr_idx_q;

	// ---------------- work stage ----------------
	logic                    valid_s1;
	logic                    kind_s1;
	logic [PC_W-1:0]         pc_s1;
	logic [LEN_W-1:0]        len_s1;
	logic                    cond_s1, ind_s1, ret_s1, call_s1, wrong_s1;
	logic [OFF_W-1:0]        off_s1;
	logic [IMM_W-1:0]        imm_s1;
	logic [PC_W-1:0]         next_s1;
	logic [DIR_ENT_W-1:0]    dir_rd_s1;
	logic [TENT_W-1:0]       tag_rd_s1;
	logic [PC_W-1:0]         addr_rd_s1;

	// ---------------- output register ----------------
	logic            pred_valid_q;
	logic [PC_W-1:0] predicted_pc_q;

	// handshake
	logic accept, s1_go, is_predict, is_train;

	// table indexes
	logic [DW-1:0] dir_idx_in, dir_idx_s1, dir_wa;
	logic [TW-1:0] tgt_idx_in, tgt_idx_s1, tgt_wa;

	// datapath
	logic [PC_W-1:0]      fall, off64, direct_tgt, pred;
	logic                 dir_set, pred_taken, train_taken, btb_hit, ras_nonempty;
	logic [1:0]           dir_cnt, cnt_new;
	logic [TAG_W-1:0]     pc_tag;
	logic [PC_W-1:0]      ras_top;
	ras_op_t              ras_op;

	// table writes
	logic                 dir_we, tag_we, addr_we;
	logic [DIR_ENT_W-1:0] dir_wd;
	logic [TENT_W-1:0]    tag_wd;

	assign is_predict = (kind_s1 == KIND_PREDICT);
	assign is_train   = (kind_s1 == KIND_TRAIN);

	// A train never needs the output register; a predict needs a free slot.
	assign s1_go     = valid_s1 && (is_train || !pred_valid_q || !pred_stall);
	assign req_stall = clearing_q || (valid_s1 && !s1_go);
	assign accept    = req_valid && !req_stall;

	assign dir_idx_in = pc[DW:1] & DIR_MASK;
	assign tgt_idx_in = pc[TW:1] & TGT_MASK;
	assign dir_idx_s1 = pc_s1[DW:1] & DIR_MASK;
	assign tgt_idx_s1 = pc_s1[TW:1] & TGT_MASK;

	// ---------------- prediction / training logic ----------------
	always_comb begin
		fall       = pc_s1 + PC_W'(len_s1);
		off64      = {{(PC_W - OFF_W){off_s1[OFF_W-1]}}, off_s1};
		direct_tgt = pc_s1 + off64;
		dir_set    = dir_rd_s1[2];
		dir_cnt    = dir_rd_s1[1:0];
		pc_tag     = pc_s1[TAG_LSB +: TAG_W];
		btb_hit    = tag_rd_s1[TAG_W] && (tag_rd_s1[TAG_W-1:0] == pc_tag);

		// unset entry: backward branch is predicted taken
		pred_taken = dir_set ? (dir_cnt >= CTR_TAKEN_LIMIT) : off_s1[OFF_W-1];

		pred = fall;
		if (cond_s1) begin
			if (pred_taken) begin
				pred = direct_tgt;
			end
		end else if (ind_s1) begin
			if (btb_hit) begin
				pred = addr_rd_s1;
			end
			if (ret_s1 && ras_nonempty && imm_s1 == '0) begin
				pred = ras_top;
			end
		end else begin
			pred = direct_tgt;
		end

		train_taken = (next_s1 != fall);
		if (!dir_set) begin
			cnt_new = train_taken ? CTR_INIT_TAKEN : CTR_INIT_NOT;
		end else if (train_taken) begin
			cnt_new = (dir_cnt == CTR_MAX) ? dir_cnt : dir_cnt + 2'd1;
		end else begin
			cnt_new = (dir_cnt == CTR_MIN) ? dir_cnt : dir_cnt - 2'd1;
		end

		ras_op.pop   = s1_go && is_predict && ret_s1;
		ras_op.push  = s1_go && is_predict && call_s1;
		ras_op.flush = s1_go && is_train && wrong_s1;

		// table write ports: the clear sweep owns them after reset
		if (clearing_q) begin
			dir_we  = ({1'b0, clr_idx_q} < DIR_N_C);
			dir_wa  = clr_idx_q[DW-1:0];
			dir_wd  = '0;
			tag_we  = ({1'b0, clr_idx_q} < TGT_N_C);
			tgt_wa  = clr_idx_q[TW-1:0];
			tag_wd  = '0;
			addr_we = 1'b0;
		end else begin
			dir_we  = s1_go && is_train && cond_s1;
			dir_wa  = dir_idx_s1;
			dir_wd  = {1'b1, cnt_new};
			tag_we  = s1_go && is_train && !cond_s1 && ind_s1;
			tgt_wa  = tgt_idx_s1;
			tag_wd  = {1'b1, pc_tag};
			addr_we = tag_we;
		end
	end

	// ---------------- clear sweep ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + CLRW'(1);
			if (clr_idx_q == CLR_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------- memories, read on accept with write forwarding ----------------
	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (accept) begin
			dir_rd_s1 <= (dir_we && dir_wa == dir_idx_in) ? dir_wd : dir_mem[dir_idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tgt_wa] <= tag_wd;
		end
		if (accept) begin
			tag_rd_s1 <= (tag_we && tgt_wa == tgt_idx_in) ? tag_wd : tag_mem[tgt_idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[tgt_wa] <= next_s1;
		end
		if (accept) begin
			addr_rd_s1 <= (addr_we && tgt_wa == tgt_idx_in) ? next_s1 : addr_mem[tgt_idx_in];
		end
	end

	// ---------------- work stage register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			pc_s1    <= pc;
			len_s1   <= inst_length;
			cond_s1  <= is_conditional;
			ind_s1   <= is_indirect;
			ret_s1   <= is_return;
			call_s1  <= is_call;
			off_s1   <= branch_offset;
			imm_s1   <= jump_immediate;
			next_s1  <= actual_next_pc;
			wrong_s1 <= mispredicted;
		end
	end

	// ---------------- return stack ----------------
	bpred_ras #(
		.RETURN_DEPTH(RETURN_DEPTH)
	) u_ras (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (ras_op),
		.push_data (fall),
		.nonempty  (ras_nonempty),
		.top       (ras_top)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_valid_q <= 1'b0;
		end else if (s1_go && is_predict) begin
			pred_valid_q <= 1'b1;
		end else if (!pred_stall) begin
			pred_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_predict) begin
			predicted_pc_q <= pred;
		end
	end

	assign pred_valid   = pred_valid_q;
	assign predicted_pc = predicted_pc_q;

	// ---------------- assertions ----------------
	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1)
		else $error("transaction in work stage during table clear");

	a_predict_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_predict && pred_valid_q && pred_stall) |=>
		(valid_s1 && $stable(pc_s1)))
		else $error("predict left work stage while result register blocked");

	a_predict_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_predict) |=> pred_valid_q)
		else $error("predict transaction produced no result");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |=> !clearing_q)
		else $error("table clear restarted");

endmodule
